### design/unsigned_to_ascii_digits_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to ASCII digit converter
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_DIGITS_ASSERT_SVH
`define UNSIGNED_TO_ASCII_DIGITS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define U2A_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");
// next-cycle implication
`define U2A_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");
`else
`define U2A_ASSERT_SAME(label, ante, cons)
`define U2A_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helper functions of the digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

	// field widths
	localparam int VALUE_W = 64;
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 7;

	// radix commands
	localparam logic [CMD_W-1:0] CMD_DEC       = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HEX_LOWER = 2'd1;
	localparam logic [CMD_W-1:0] CMD_HEX_UPPER = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD      = 2'd3;

	// ASCII anchors
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

	// BCD register: 20 decimal digits cover 2^64-1
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int POS_W      = $clog2(NUM_DIGITS);

	// double dabble: one byte of the value per cycle
	localparam int BITS_PER_STEP = 8;
	localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(CONV_STEPS);

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// classified item handed from front to back
	typedef struct packed {
		logic               hex;
		logic               upper;
		logic [VALUE_W-1:0] value;
	} item_t;

	// back-end sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} back_state_t;

	// eight shift-add-3 steps, MSB of the byte first
	function automatic logic [BCD_W-1:0] dabble_byte(input logic [BCD_W-1:0] bcd_in,
		input logic [BITS_PER_STEP-1:0] bits);
		logic [BCD_W-1:0] bcd;
		bcd = bcd_in;
		for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
			for (int j = 0; j < NUM_DIGITS; j++) begin
				if (bcd[j*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					bcd[j*DIGIT_W +: DIGIT_W] = bcd[j*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			bcd = {bcd[BCD_W-2:0], bits[b]};
		end
		return bcd;
	endfunction

	// index of the most significant nonzero digit, 0 when all are zero
	function automatic logic [POS_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
		logic [POS_W-1:0] idx;
		idx = '0;
		for (int j = 0; j < NUM_DIGITS; j++) begin
			if (bcd[j*DIGIT_W +: DIGIT_W] != '0) begin
				idx = POS_W'(j);
			end
		end
		return idx;
	endfunction

	// one digit to its ASCII code
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
		input logic upper);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'b000, d};
		end else if (upper) begin
			c = CHAR_UPPER_A + {3'b000, d - 4'd10};
		end else begin
			c = CHAR_LOWER_A + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### design/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front
// Accepts input transfers, decodes the radix command and queues the items.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_front #(
	parameter int QueueDepth = u2a_pkg::QUEUE_DEPTH
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [u2a_pkg::VALUE_W-1:0]    s_tdata,  // [63:0] value
	input  wire  [u2a_pkg::CMD_W-1:0]      s_tuser,  // [1:0] cmd
	output u2a_pkg::item_t                 q_item,
	output logic                           q_valid,
	input  wire                            q_ready
);

	localparam int PTR_W = $clog2(QueueDepth);
	localparam int CNT_W = $clog2(QueueDepth + 1);

	u2a_pkg::item_t     mem_q [QueueDepth];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	u2a_pkg::item_t     item_in;
	logic               push;
	logic               pop;

	// radix decode; the undefined code falls in with upper-case hex
	always_comb begin
		item_in.value = s_tdata;
		unique case (s_tuser) inside
			u2a_pkg::CMD_DEC: begin
				item_in.hex   = 1'b0;
				item_in.upper = 1'b0;
			end
			u2a_pkg::CMD_HEX_LOWER: begin
				item_in.hex   = 1'b1;
				item_in.upper = 1'b0;
			end
			u2a_pkg::CMD_HEX_UPPER, u2a_pkg::CMD_RSVD: begin
				item_in.hex   = 1'b1;
				item_in.upper = 1'b1;
			end
		endcase
	end

	// handshake
	assign s_tready = (count_q != CNT_W'(QueueDepth));
	assign q_valid  = (count_q != '0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back
// Converts one queued item to digits and sends them out, MSD first.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  u2a_pkg::item_t               q_item,
	input  wire                          q_valid,
	output logic                         q_ready,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,  // [6:0] digit_char, [7] zero
	output logic                         m_tlast   // last
);

	u2a_pkg::back_state_t               state_q;
	u2a_pkg::back_state_t               state_d;
	logic [u2a_pkg::VALUE_W-1:0]        bin_q;
	logic [u2a_pkg::BCD_W-1:0]          bcd_q;
	logic                               upper_q;
	logic [u2a_pkg::STEP_W-1:0]         step_q;
	logic [u2a_pkg::POS_W-1:0]          pos_q;
	logic [u2a_pkg::CHAR_W-1:0]         out_char_q;
	logic                               out_last_q;
	logic                               out_valid_q;
	logic                               emit_fire;
	logic                               conv_done;

	assign conv_done = (step_q == u2a_pkg::STEP_W'(u2a_pkg::CONV_STEPS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u2a_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = q_item.hex ? u2a_pkg::ST_FIND : u2a_pkg::ST_CONV;
				end
			end
			u2a_pkg::ST_CONV: begin
				if (conv_done) begin
					state_d = u2a_pkg::ST_FIND;
				end
			end
			u2a_pkg::ST_FIND: begin
				state_d = u2a_pkg::ST_EMIT;
			end
			u2a_pkg::ST_EMIT: begin
				if (emit_fire && (pos_q == '0)) begin
					state_d = u2a_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = u2a_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		q_ready   = (state_q == u2a_pkg::ST_IDLE);
		emit_fire = (state_q == u2a_pkg::ST_EMIT) && (!out_valid_q || m_tready);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= u2a_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: load, byte-wise double dabble, digit search, emit
	always_ff @(posedge clk) begin
		case (state_q)
			u2a_pkg::ST_IDLE: begin
				if (q_valid) begin
					upper_q <= q_item.upper;
					bin_q   <= q_item.value;
					step_q  <= '0;
					// hex nibbles are already the digits
					bcd_q   <= q_item.hex ?
						{{(u2a_pkg::BCD_W - u2a_pkg::VALUE_W){1'b0}}, q_item.value} : '0;
				end
			end
			u2a_pkg::ST_CONV: begin
				bcd_q  <= u2a_pkg::dabble_byte(bcd_q,
					bin_q[u2a_pkg::VALUE_W-1 -: u2a_pkg::BITS_PER_STEP]);
				bin_q  <= bin_q << u2a_pkg::BITS_PER_STEP;
				step_q <= step_q + 1'b1;
			end
			u2a_pkg::ST_FIND: begin
				pos_q <= u2a_pkg::msd_index(bcd_q);
			end
			u2a_pkg::ST_EMIT: begin
				if (emit_fire) begin
					out_char_q <= u2a_pkg::digit_to_ascii(
						bcd_q[{pos_q, 2'b00} +: u2a_pkg::DIGIT_W], upper_q);
					out_last_q <= (pos_q == '0);
					pos_q      <= pos_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

### design/unsigned_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// 64-bit unsigned value to ASCII decimal or hex digits, MSD first.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata             | tuser     | tlast
//  s_*      | in  | [63:0] value      | [1:0] cmd | -
//  m_*      | out | [6:0] digit_char  | -         | last
//
// Decimal items pass through the back end as load, byte-wise double dabble,
// digit search and emission of one character per cycle while m_tready allows;
// hex items skip the double dabble. A number has 1 to 20 decimal or 1 to 16 hex characters.
// The front queue (QueueDepth items) takes new transfers while the back works.
// A stalled m_tready holds the output register and pauses character emission.
// arst_n clears the queue, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsigned_to_ascii_digits_assert.svh"

module unsigned_to_ascii_digits #(
	parameter int QueueDepth = u2a_pkg::QUEUE_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [u2a_pkg::VALUE_W-1:0]  s_tdata,  // [63:0] value
	input  wire  [u2a_pkg::CMD_W-1:0]    s_tuser,  // [1:0] cmd
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,  // [6:0] digit_char, [7] zero
	output logic                         m_tlast   // last
);

	u2a_pkg::item_t q_item;
	logic           q_valid;
	logic           q_ready;

	// accept and classify
	u2a_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready)
	);

	// convert and emit
	u2a_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// a full queue is never empty
	`U2A_ASSERT_SAME(a_full_has_item, !s_tready, q_valid)
	// the back end is busy right after taking an item
	`U2A_ASSERT_NEXT(a_take_then_busy, q_valid && q_ready, !q_ready)
	// every character out is a digit of one of the radices
	`U2A_ASSERT_SAME(a_char_is_digit, m_tvalid, (m_tdata >= 8'h30 && m_tdata <= 8'h39) || (m_tdata >= 8'h41 && m_tdata <= 8'h46) || (m_tdata >= 8'h61 && m_tdata <= 8'h66))

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives 64-bit values with decimal and hex radix commands into the digit
// converter and checks every ASCII character and its end-of-number flag
// against directed expected text or a behavioral digit generator, under random gaps and back-pressure.
// ----------------------------------------------------------------------------

module testbench;

	import u2a_pkg::*;

	localparam int NUM_RANDOM = 300;

	// one expected output character
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	// directed stimulus row; empty text means the generator supplies it
	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [VALUE_W-1:0] value;
		string              text;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [VALUE_W-1:0]  s_tdata;
	logic [CMD_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;
	logic                m_tlast;

	digit_t   pending_digits[$];
	dir_row_t dir_rows[$];
	int       err_count = 0;
	int       cycle_count = 0;
	bit       sending = 1'b1;

	unsigned_to_ascii_digits DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// expected characters of one number, most significant first
	function automatic void push_digits(input logic [CMD_W-1:0] cmd,
		input logic [VALUE_W-1:0] value);
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] base;
		logic [3:0]         d;
		logic [CHAR_W-1:0]  rev[NUM_DIGITS];
		logic               upper;
		int                 n;
		upper = (cmd == CMD_HEX_UPPER) || (cmd == CMD_RSVD);
		base = (cmd == CMD_DEC) ? 64'd10 : 64'd16;
		v = value;
		n = 0;
		// zero still yields one digit
		do begin
			d = 4'(v % base);
			if (d < 4'd10)
				rev[n] = CHAR_ZERO + CHAR_W'(d);
			else if (upper)
				rev[n] = CHAR_UPPER_A + CHAR_W'(d - 4'd10);
			else
				rev[n] = CHAR_LOWER_A + CHAR_W'(d - 4'd10);
			v = v / base;
			n++;
		end while (v != '0);
		for (int k = n - 1; k >= 0; k--) begin
			pending_digits.push_back('{ch: rev[k], last: (k == 0)});
		end
	endfunction

	// present one transfer and wait until it is taken
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
		input string text);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (text.len() == 0) begin
			push_digits(cmd, value);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				pending_digits.push_back('{ch: CHAR_W'(text[i]),
					last: (i == text.len() - 1)});
			end
		end
	endtask

	// random sender gap after a transfer, none inside the quiet stretch
	task automatic maybe_idle(input bit quiet);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 9) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= CMD_W'($urandom_range(0, 3));
			repeat (gap) @(posedge clk);
		end
	endtask

	// random value with a spread of digit counts
	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] p;
		int                 k;
		case ($urandom_range(0, 9))
			0: rand_value = VALUE_W'($urandom_range(0, 20));
			1: rand_value = {VALUE_W{1'b1}} >> $urandom_range(0, 63);
			2, 3: begin
				// powers of ten and one below, the decimal length steps
				k = $urandom_range(0, 19);
				p = 64'd1;
				repeat (k) p = p * 64'd10;
				rand_value = p - VALUE_W'($urandom_range(0, 1));
			end
			default: rand_value = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	// sender: directed table, then random items
	initial begin
		logic [CMD_W-1:0] cmd;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_DEC;

		dir_rows.push_back('{CMD_DEC,       64'd0, "0"});
		dir_rows.push_back('{CMD_HEX_LOWER, 64'd0, "0"});
		dir_rows.push_back('{CMD_HEX_UPPER, 64'd0, "0"});
		dir_rows.push_back('{CMD_RSVD,      64'd0, "0"});
		dir_rows.push_back('{CMD_DEC,       64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"});
		dir_rows.push_back('{CMD_HEX_LOWER, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"});
		dir_rows.push_back('{CMD_HEX_UPPER, 64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"});
		dir_rows.push_back('{CMD_RSVD,      64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"});
		dir_rows.push_back('{CMD_DEC,       64'd1, "1"});
		dir_rows.push_back('{CMD_DEC,       64'd9, "9"});
		dir_rows.push_back('{CMD_DEC,       64'd10, "10"});
		dir_rows.push_back('{CMD_HEX_LOWER, 64'd15, "f"});
		dir_rows.push_back('{CMD_HEX_UPPER, 64'd16, "10"});
		dir_rows.push_back('{CMD_DEC,       64'h8000_0000_0000_0000, "9223372036854775808"});
		dir_rows.push_back('{CMD_DEC,       64'd10000000000000000000, "10000000000000000000"});
		dir_rows.push_back('{CMD_HEX_LOWER, 64'h0123_4567_89AB_CDEF, "123456789abcdef"});
		dir_rows.push_back('{CMD_HEX_UPPER, 64'hFEDC_BA98_7654_3210, "FEDCBA9876543210"});
		dir_rows.push_back('{CMD_RSVD,      64'h0000_0000_00AB_CDEF, "ABCDEF"});
		dir_rows.push_back('{CMD_DEC,       64'd999, ""});
		dir_rows.push_back('{CMD_DEC,       64'd5555555555, ""});
		dir_rows.push_back('{CMD_HEX_LOWER, 64'hA5A5_5A5A_A5A5_5A5A, ""});
		dir_rows.push_back('{CMD_RSVD,      64'h0000_0001_0000_0000, ""});

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].text);
			maybe_idle(1'b0);
		end

		for (int i = 0; i < NUM_RANDOM; i++) begin
			cmd = CMD_W'($urandom_range(0, 3));
			send_item(cmd, rand_value(), "");
			maybe_idle(i >= 150 && i < 200);
		end
		s_tvalid <= 1'b0;
		sending = 1'b0;

		// drain, then give late extra characters a chance to show up
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// receiver: random stalls, one long hold-off, one quiet stretch
	initial begin
		int  stall_left;
		bit  held;
		stall_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sending && cycle_count >= 1500) begin
				// long hold so the input side backs up
				held = 1'b1;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!(cycle_count >= 3000 && cycle_count < 5000)
				&& $urandom_range(0, 99) < 3) begin
				// short random stalls, about 9 percent overall
				stall_left = $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// output check against the oldest expected character
	always @(posedge clk) begin : char_check
		digit_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual char=%h last=%b",
					$time, m_tdata[CHAR_W-1:0], m_tlast);
				err_count++;
			end else begin
				want = pending_digits.pop_front();
				if (m_tdata[CHAR_W-1:0] !== want.ch) begin
					$display("%0t: digit_char mismatch, expected %h actual %h",
						$time, want.ch, m_tdata[CHAR_W-1:0]);
					err_count++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last mismatch, expected %b actual %b",
						$time, want.last, m_tlast);
					err_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/u2a_pkg.sv
design/u2a_front.sv
design/u2a_back.sv
design/unsigned_to_ascii_digits.sv
sim/testbench.sv
